### hdl/uklt_pkg.sv
package uklt_pkg;

   // Operation codes carried by an input beat.
   localparam logic [1:0] OP_ADD    = 2'd0;
   localparam logic [1:0] OP_REMOVE = 2'd1;
   localparam logic [1:0] OP_FIND   = 2'd2;

   // Result status codes.
   localparam logic [1:0] STAT_OK       = 2'd0;
   localparam logic [1:0] STAT_DUP      = 2'd1;
   localparam logic [1:0] STAT_NOTFOUND = 2'd2;
   localparam logic [1:0] STAT_FULL     = 2'd3;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MATCH,
      ST_EXEC
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;
      logic match;
      logic exec;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic rsp_busy;
   } stat_type;

endpackage

### hdl/unique_key_list_table.sv
// Ordered table of distinct keys, kept in the order they were added.
// Input channel (req_): one beat carries an opcode (add, remove, find) and a
// key. Result channel (rsp_): exactly one beat per input beat, carrying a
// status, the position of the entry concerned and the entry count after the
// operation. Remove closes the gap by moving every later entry down by one.
// Each input beat is handled in order: it is captured, its key is compared
// against every stored entry at once, and then the lowest match is resolved,
// the table is updated and the result register is loaded. req_ready is high
// only while the controller is idle, so a new beat is not accepted until the
// previous one has finished its update step.
// The result register holds a finished beat while the next input beat is
// accepted and compared; if the receiver stalls, the update step waits until
// the result register is free, and no beat is lost or repeated.
// A synchronous reset empties the table at once by clearing the entry count;
// the key storage itself is not cleared, since slots beyond the count are
// never compared. No result is pending after reset.
module unique_key_list_table #(
   parameter int TABLE_DEPTH = 16,
   parameter int KEY_WIDTH   = 32,
   localparam int POS_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1,
   localparam int CNT_W      = $clog2(TABLE_DEPTH + 1)
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [1:0]           req_opcode,
   input  logic [KEY_WIDTH-1:0] req_key,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [1:0]           rsp_status,
   output logic [POS_W-1:0]     rsp_position,
   output logic [CNT_W-1:0]     rsp_entry_count
);

   // Command and status bundles between the controller and the datapath.
   uklt_pkg::cmd_type  cmd;
   uklt_pkg::stat_type stat;

   // The controller sequences capture, compare and update for each beat.
   uklt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // The datapath holds the key storage, the compare row and the result register.
   uklt_dpath #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .KEY_WIDTH   (KEY_WIDTH),
      .POS_W       (POS_W),
      .CNT_W       (CNT_W)
   ) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .req_opcode      (req_opcode),
      .req_key         (req_key),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_position    (rsp_position),
      .rsp_entry_count (rsp_entry_count)
   );

endmodule

### hdl/uklt_ctrl.sv
module uklt_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  uklt_pkg::stat_type stat,
   output uklt_pkg::cmd_type  cmd
);

   uklt_pkg::state_type state_ff;
   uklt_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= uklt_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         uklt_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = uklt_pkg::ST_MATCH;
            end
         end
         uklt_pkg::ST_MATCH: begin
            state_in = uklt_pkg::ST_EXEC;
         end
         uklt_pkg::ST_EXEC: begin
            if (!stat.rsp_busy) begin
               state_in = uklt_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = uklt_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready   = 1'b0;
      cmd.capture = 1'b0;
      cmd.match   = 1'b0;
      cmd.exec    = 1'b0;
      unique case (state_ff)
         uklt_pkg::ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
         end
         uklt_pkg::ST_MATCH: begin
            cmd.match = 1'b1;
         end
         uklt_pkg::ST_EXEC: begin
            // The result register must be free before the table is changed.
            cmd.exec = !stat.rsp_busy;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

endmodule

### hdl/uklt_dpath.sv
module uklt_dpath #(
   parameter int TABLE_DEPTH = 16,
   parameter int KEY_WIDTH   = 32,
   parameter int POS_W       = 4,
   parameter int CNT_W       = 5
) (
   input  logic                 clock,
   input  logic                 reset,
   input  uklt_pkg::cmd_type    cmd,
   output uklt_pkg::stat_type   stat,
   input  logic [1:0]           req_opcode,
   input  logic [KEY_WIDTH-1:0] req_key,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [1:0]           rsp_status,
   output logic [POS_W-1:0]     rsp_position,
   output logic [CNT_W-1:0]     rsp_entry_count
);

   logic [1:0]             op_ff;
   logic [KEY_WIDTH-1:0]   key_ff;
   logic [KEY_WIDTH-1:0]   store_ff [TABLE_DEPTH];
   logic [TABLE_DEPTH-1:0] match_ff;
   logic [CNT_W-1:0]       count_ff;
   logic [CNT_W-1:0]       count_in;

   logic                   rsp_valid_ff;
   logic [1:0]             rsp_status_ff;
   logic [POS_W-1:0]       rsp_position_ff;
   logic [CNT_W-1:0]       rsp_count_ff;

   logic                   found;
   logic [POS_W-1:0]       hit;
   logic                   full;
   logic                   add_ok;
   logic                   remove_ok;
   logic [1:0]             status_in;
   logic [POS_W-1:0]       position_in;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff  <= req_opcode;
         key_ff <= req_key;
      end
   end

   // Compare every stored entry against the key; slots past the count never hit.
   always_ff @(posedge clock) begin
      if (cmd.match) begin
         for (int i = 0; i < TABLE_DEPTH; i++) begin
            match_ff[i] <= (store_ff[i] == key_ff) && (CNT_W'(i) < count_ff);
         end
      end
   end

   // Lowest matching index.
   always_comb begin
      found = 1'b0;
      hit   = '0;
      for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
         if (match_ff[i]) begin
            found = 1'b1;
            hit   = POS_W'(i);
         end
      end
   end

   assign full      = (count_ff == CNT_W'(TABLE_DEPTH));
   assign add_ok    = (op_ff == uklt_pkg::OP_ADD) && !found && !full;
   assign remove_ok = (op_ff == uklt_pkg::OP_REMOVE) && found;

   always_comb begin
      status_in   = uklt_pkg::STAT_NOTFOUND;
      position_in = '0;
      count_in    = count_ff;
      case (op_ff)
         uklt_pkg::OP_ADD: begin
            if (found) begin
               status_in   = uklt_pkg::STAT_DUP;
               position_in = hit;
            end else if (full) begin
               status_in = uklt_pkg::STAT_FULL;
            end else begin
               status_in   = uklt_pkg::STAT_OK;
               position_in = count_ff[POS_W-1:0];
               count_in    = count_ff + CNT_W'(1);
            end
         end
         uklt_pkg::OP_REMOVE: begin
            if (found) begin
               status_in   = uklt_pkg::STAT_OK;
               position_in = hit;
               count_in    = count_ff - CNT_W'(1);
            end
         end
         uklt_pkg::OP_FIND: begin
            if (found) begin
               status_in   = uklt_pkg::STAT_OK;
               position_in = hit;
            end
         end
         default: begin
            status_in = uklt_pkg::STAT_NOTFOUND;
         end
      endcase
   end

   // Each slot either takes the new key or, below the top slot, its upper neighbour on removal.
   for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_slot
      if (g < TABLE_DEPTH - 1) begin : g_shift
         always_ff @(posedge clock) begin
            if (cmd.exec) begin
               if (add_ok && (count_ff[POS_W-1:0] == POS_W'(g))) begin
                  store_ff[g] <= key_ff;
               end else if (remove_ok && (POS_W'(g) >= hit)) begin
                  store_ff[g] <= store_ff[g+1];
               end
            end
         end
      end else begin : g_top
         always_ff @(posedge clock) begin
            if (cmd.exec && add_ok && (count_ff[POS_W-1:0] == POS_W'(g))) begin
               store_ff[g] <= key_ff;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.exec) begin
            count_ff     <= count_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         rsp_status_ff   <= status_in;
         rsp_position_ff <= position_in;
         rsp_count_ff    <= count_in;
      end
   end

   assign stat.rsp_busy   = rsp_valid_ff && !rsp_ready;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_position    = rsp_position_ff;
   assign rsp_entry_count = rsp_count_ff;

endmodule

### test/unique_key_list_table_tb.sv
`timescale 1ns / 100ps

// Self-checking bench for the ordered key table. A short table of directed
// beats walks the corners (empty table, all-zero and all-ones keys, the
// unused opcode, a full table, a duplicate offered to a full table, a remove
// that shifts every entry) and is followed by a long run of random beats
// which fill and drain the table repeatedly. Every accepted input beat is
// run through a shadow copy of the table, and the resulting expectation is
// queued until the matching result beat comes back.
module unique_key_list_table_tb;

   localparam int TABLE_DEPTH = 16;
   localparam int KEY_WIDTH   = 32;
   localparam int POS_W       = 4;
   localparam int CNT_W       = 5;

   // Opcode 3 is not defined by the block. It must be ignored, but still
   // answered with a not-found result beat.
   localparam logic [1:0] OP_UNUSED = 2'd3;

   localparam int RANDOM_BEATS   = 925;
   localparam int TAIL_BEATS     = 120;   // final stretch with no idling at all
   localparam int HOLD_AT_BEAT   = 300;   // receiver holds off here
   localparam int DRAIN_AT_BEAT  = 600;   // sender waits for all results here
   localparam int HOLD_CYCLES    = 80;
   localparam int POOL_SIZE      = 24;    // more keys than slots, so it fills up
   localparam int DRAIN_CYCLES   = 12;
   localparam int WATCHDOG_LIMIT = 2000;

   typedef struct packed {
      logic [1:0]       status;
      logic [POS_W-1:0] position;
      logic [CNT_W-1:0] entry_count;
   } key_result_type;

   typedef struct packed {
      logic [1:0]           opcode;
      logic [KEY_WIDTH-1:0] key;
      logic                 typed;   // result below was written by hand
      key_result_type       result;
   } stim_row_type;

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   logic [1:0]           req_opcode;
   logic [KEY_WIDTH-1:0] req_key;
   logic                 rsp_valid;
   logic                 rsp_ready;
   logic [1:0]           rsp_status;
   logic [POS_W-1:0]     rsp_position;
   logic [CNT_W-1:0]     rsp_entry_count;

   // Shadow copy of the table contents, kept in step with accepted beats.
   logic [KEY_WIDTH-1:0] shadow_keys [TABLE_DEPTH];
   int                   shadow_count;

   key_result_type pending_results [$];
   stim_row_type   stim_table [$];
   logic [KEY_WIDTH-1:0] key_pool [POOL_SIZE];

   int mismatch_count;
   int beats_sent;
   int results_seen;
   int status_seen [4];
   int peak_count;
   int holds_done;
   int drains_done;
   bit hold_rsp;
   bit quiet_tail;

   unique_key_list_table #(
      .TABLE_DEPTH(TABLE_DEPTH),
      .KEY_WIDTH  (KEY_WIDTH)
   ) DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_opcode     (req_opcode),
      .req_key        (req_key),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_status     (rsp_status),
      .rsp_position   (rsp_position),
      .rsp_entry_count(rsp_entry_count)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   task automatic report_mismatch(input string what);
      mismatch_count++;
      $display("%0t: mismatch: %s", $realtime, what);
   endtask

   // Applies one operation to the shadow table and returns the result beat
   // that the block should produce for it. The lowest matching slot wins,
   // and only slots below the count are ever compared.
   function automatic key_result_type apply_key_op(input logic [1:0] op,
                                                   input logic [KEY_WIDTH-1:0] key);
      key_result_type res;
      bit             hit;
      int             where;
      int             i;
      hit   = 1'b0;
      where = 0;
      for (i = 0; i < shadow_count; i++) begin
         if (!hit && shadow_keys[i] == key) begin
            hit   = 1'b1;
            where = i;
         end
      end
      res.status   = uklt_pkg::STAT_NOTFOUND;
      res.position = '0;
      case (op)
         uklt_pkg::OP_ADD: begin
            // A duplicate is reported ahead of a full table.
            if (hit) begin
               res.status   = uklt_pkg::STAT_DUP;
               res.position = POS_W'(where);
            end else if (shadow_count >= TABLE_DEPTH) begin
               res.status = uklt_pkg::STAT_FULL;
            end else begin
               shadow_keys[shadow_count] = key;
               res.position = POS_W'(shadow_count);
               res.status   = uklt_pkg::STAT_OK;
               shadow_count++;
            end
         end
         uklt_pkg::OP_REMOVE: begin
            if (hit) begin
               // Close the gap: every later entry moves down by one slot.
               for (i = where; i + 1 < shadow_count; i++) begin
                  shadow_keys[i] = shadow_keys[i + 1];
               end
               shadow_count--;
               res.status   = uklt_pkg::STAT_OK;
               res.position = POS_W'(where);
            end
         end
         uklt_pkg::OP_FIND: begin
            if (hit) begin
               res.status   = uklt_pkg::STAT_OK;
               res.position = POS_W'(where);
            end
         end
         default: begin
         end
      endcase
      res.entry_count = CNT_W'(shadow_count);
      return res;
   endfunction

   function automatic void add_row(input logic [1:0] op, input logic [KEY_WIDTH-1:0] key,
                                   input logic typed, input logic [1:0] status,
                                   input int position, input int count);
      stim_row_type row;
      row.opcode             = op;
      row.key                = key;
      row.typed              = typed;
      row.result.status      = status;
      row.result.position    = POS_W'(position);
      row.result.entry_count = CNT_W'(count);
      stim_table = {stim_table, row};
   endfunction

   // Offers one beat from the next falling edge and holds it until the block
   // takes it. Valid is not lowered between back-to-back beats. The shadow
   // table is updated at the accepting edge, so later beats see its effect.
   task automatic send_beat(input logic [1:0] op, input logic [KEY_WIDTH-1:0] key,
                            input logic use_given, input key_result_type given);
      key_result_type predicted;
      @(negedge clock);
      req_valid  = 1'b1;
      req_opcode = op;
      req_key    = key;
      do @(posedge clock); while (!req_ready);
      predicted = apply_key_op(op, key);
      pending_results = {pending_results, (use_given ? given : predicted)};
      beats_sent++;
   endtask

   // Drops valid for a number of cycles. The payload is scrambled meanwhile,
   // since the block must ignore it.
   task automatic idle_sender(input int cycles);
      @(negedge clock);
      req_valid  = 1'b0;
      req_opcode = 2'($urandom);
      req_key    = $urandom;
      repeat (cycles - 1) @(negedge clock);
   endtask

   // Result side: every accepted beat is compared, field by field, with the
   // oldest outstanding expectation.
   always @(posedge clock) begin
      key_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         results_seen++;
         status_seen[rsp_status]++;
         if (int'(rsp_entry_count) > peak_count) begin
            peak_count = int'(rsp_entry_count);
         end
         if (pending_results.size() == 0) begin
            report_mismatch($sformatf("result beat with nothing outstanding (status %0d)",
                                      rsp_status));
         end else begin
            want = pending_results.pop_front();
            if (rsp_status !== want.status) begin
               report_mismatch($sformatf("result %0d: status %0d, expected %0d",
                                         results_seen, rsp_status, want.status));
            end
            if (rsp_position !== want.position) begin
               report_mismatch($sformatf("result %0d: position %0d, expected %0d",
                                         results_seen, rsp_position, want.position));
            end
            if (rsp_entry_count !== want.entry_count) begin
               report_mismatch($sformatf("result %0d: entry count %0d, expected %0d",
                                         results_seen, rsp_entry_count, want.entry_count));
            end
         end
      end
   end

   // Receiver: random bursts of stall and of readiness, a single long
   // hold-off on request, and no stalls at all in the closing stretch.
   initial begin
      int stall_left;
      int ready_left;
      rsp_ready  = 1'b0;
      stall_left = 0;
      ready_left = 0;
      forever begin
         @(negedge clock);
         if (hold_rsp) begin
            // Long enough for the block to fill up and refuse further beats.
            rsp_ready = 1'b0;
            repeat (HOLD_CYCLES - 1) @(negedge clock);
            hold_rsp = 1'b0;
            holds_done++;
         end else if (quiet_tail) begin
            rsp_ready = 1'b1;
         end else if (stall_left > 0) begin
            rsp_ready = 1'b0;
            stall_left--;
         end else if (ready_left > 0) begin
            rsp_ready = 1'b1;
            ready_left--;
         end else if ($urandom_range(0, 2) == 0) begin
            rsp_ready  = 1'b0;
            stall_left = $urandom_range(1, 15) - 1;
         end else begin
            rsp_ready  = 1'b1;
            ready_left = $urandom_range(1, 40) - 1;
         end
      end
   end

   // Watchdog: a run in which nothing moves on either channel for this long
   // has hung.
   initial begin
      int still_cycles;
      still_cycles = 0;
      forever begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            still_cycles = 0;
         end else begin
            still_cycles++;
         end
         if (still_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog expired with %0d results outstanding.",
                     pending_results.size());
            $display("unique_key_list_table_tb: FAIL");
            $finish;
         end
      end
   end

   // Sender and overall sequence.
   initial begin
      logic [1:0]           op;
      logic [KEY_WIDTH-1:0] key;
      logic [KEY_WIDTH-1:0] fill_key;
      key_result_type       no_result;
      bit                   filling;
      bit                   sender_steady;
      int                   pick;
      int                   i;
      int                   n;

      reset      = 1'b1;
      req_valid  = 1'b0;
      req_opcode = uklt_pkg::OP_ADD;
      req_key    = '0;
      hold_rsp   = 1'b0;
      quiet_tail = 1'b0;
      no_result  = '0;
      filling    = 1'b1;
      sender_steady = 1'b0;
      shadow_count  = 0;
      for (i = 0; i < TABLE_DEPTH; i++) begin
         shadow_keys[i] = '0;
      end

      // Directed corners. Rows with an obvious answer carry it by hand; the
      // rest rely on the shadow table.
      add_row(uklt_pkg::OP_FIND,   32'h0000_0000, 1'b1, uklt_pkg::STAT_NOTFOUND, 0, 0);
      add_row(uklt_pkg::OP_REMOVE, 32'hFFFF_FFFF, 1'b1, uklt_pkg::STAT_NOTFOUND, 0, 0);
      add_row(OP_UNUSED,           32'h0000_0000, 1'b1, uklt_pkg::STAT_NOTFOUND, 0, 0);
      add_row(uklt_pkg::OP_ADD,    32'h0000_0000, 1'b1, uklt_pkg::STAT_OK,       0, 1);
      add_row(uklt_pkg::OP_ADD,    32'hFFFF_FFFF, 1'b1, uklt_pkg::STAT_OK,       1, 2);
      add_row(uklt_pkg::OP_ADD,    32'h0000_0000, 1'b1, uklt_pkg::STAT_DUP,      0, 2);
      add_row(uklt_pkg::OP_FIND,   32'hFFFF_FFFF, 1'b1, uklt_pkg::STAT_OK,       1, 2);
      // The unused opcode must not find a key that is stored.
      add_row(OP_UNUSED,           32'hFFFF_FFFF, 1'b1, uklt_pkg::STAT_NOTFOUND, 0, 2);
      // Fill the table, starting with keys one bit away from those stored.
      for (i = 0; i < TABLE_DEPTH - 2; i++) begin
         fill_key = (i == 0) ? 32'hFFFF_FFFE :
                    (i == 1) ? 32'h0000_0001 :
                    (i == 2) ? 32'h7FFF_FFFF : (32'hA5A5_0000 | i);
         add_row(uklt_pkg::OP_ADD, fill_key, 1'b0, uklt_pkg::STAT_OK, 0, 0);
      end
      add_row(uklt_pkg::OP_ADD,    32'h1234_5678, 1'b1, uklt_pkg::STAT_FULL, 0, 16);
      // A duplicate still wins over a full table.
      add_row(uklt_pkg::OP_ADD,    32'hFFFF_FFFF, 1'b1, uklt_pkg::STAT_DUP,  1, 16);
      add_row(uklt_pkg::OP_FIND,   32'hA5A5_000D, 1'b0, uklt_pkg::STAT_OK,   0, 0);
      // Removing the first entry shifts every other entry down.
      add_row(uklt_pkg::OP_REMOVE, 32'h0000_0000, 1'b1, uklt_pkg::STAT_OK,   0, 15);
      add_row(uklt_pkg::OP_FIND,   32'hFFFF_FFFF, 1'b0, uklt_pkg::STAT_OK,   0, 0);

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (stim_table[r]) begin
         if ($urandom_range(0, 3) == 0) begin
            idle_sender($urandom_range(1, 15));
         end
         send_beat(stim_table[r].opcode, stim_table[r].key,
                   stim_table[r].typed, stim_table[r].result);
      end

      // Random part. Keys are drawn mostly from the table itself, from
      // near misses of stored keys and from a small pool, so that hits,
      // duplicates and a full table come up often. The opcode mix swings
      // between filling and draining.
      for (n = 0; n < RANDOM_BEATS; n++) begin
         quiet_tail = (n >= RANDOM_BEATS - TAIL_BEATS);
         if (n % 200 == 0) begin
            for (i = 0; i < POOL_SIZE; i++) begin
               key_pool[i] = $urandom;
            end
         end
         if (n % 64 == 0) begin
            sender_steady = ($urandom_range(0, 2) == 0);
         end
         if (n == HOLD_AT_BEAT) begin
            hold_rsp = 1'b1;
         end
         if (n == DRAIN_AT_BEAT) begin
            idle_sender(1);
            while (pending_results.size() != 0) @(posedge clock);
            drains_done++;
         end

         if (shadow_count == TABLE_DEPTH) begin
            filling = 1'b0;
         end else if (shadow_count == 0) begin
            filling = 1'b1;
         end
         pick = $urandom_range(0, 99);
         if (pick < 3) begin
            op = OP_UNUSED;
         end else if (pick < (filling ? 58 : 23)) begin
            op = uklt_pkg::OP_ADD;
         end else if (pick < (filling ? 78 : 73)) begin
            op = uklt_pkg::OP_REMOVE;
         end else begin
            op = uklt_pkg::OP_FIND;
         end

         pick = $urandom_range(0, 99);
         if (pick < 45 && shadow_count > 0) begin
            key = shadow_keys[$urandom_range(0, shadow_count - 1)];
         end else if (pick < 60 && shadow_count > 0) begin
            key = shadow_keys[$urandom_range(0, shadow_count - 1)]
                  ^ (32'd1 << $urandom_range(0, KEY_WIDTH - 1));
         end else if (pick < 90) begin
            key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
         end else begin
            key = $urandom;
         end

         if (!quiet_tail && !sender_steady && $urandom_range(0, 3) == 0) begin
            idle_sender($urandom_range(1, 15));
         end
         send_beat(op, key, 1'b0, no_result);
      end

      idle_sender(1);
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Covered %0d input beats (%0d directed) and %0d results: ok %0d, dup %0d, %s",
               beats_sent, stim_table.size(), results_seen,
               status_seen[uklt_pkg::STAT_OK], status_seen[uklt_pkg::STAT_DUP],
               $sformatf("not found %0d, full %0d.",
                         status_seen[uklt_pkg::STAT_NOTFOUND],
                         status_seen[uklt_pkg::STAT_FULL]));
      $display("Table peaked at %0d entries; %0d long hold-off(s), %0d drain pause(s).",
               peak_count, holds_done, drains_done);
      if (mismatch_count == 0) begin
         $display("unique_key_list_table_tb: PASS");
      end else begin
         $display("unique_key_list_table_tb: FAIL");
      end
      $finish;
   end

endmodule
